@@ hdl/cq_pkg.sv @@
package cq_pkg;

  localparam int DEPTH_DEF  = 32;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_W      = 6;
  localparam int SIZE_RESET = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_INVALID = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BAD_OP = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PUT
  } state_t;

  // Description of one result beat handed from the sequencer to the output stage.
  typedef struct packed {
    status_t status;
    logic    last;
    logic    from_ram;
  } res_t;

endpackage

@@ hdl/cq_ram.sv @@
module cq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/cq_ctrl.sv @@
module cq_ctrl
  import cq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W  = $clog2(DEPTH),
  localparam int SIZE_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  input  logic                     out_free,
  output logic                     res_load,
  output res_t                     res,
  output logic                     ram_we,
  output logic [IDX_W-1:0]         ram_waddr,
  output logic [DATA_W-1:0]        ram_wdata,
  output logic                     ram_re,
  output logic [IDX_W-1:0]         ram_raddr
);

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [DATA_W-1:0]    val_r, val_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [IDX_W-1:0]     walk_r, walk_nxt;
  logic [SIZE_W-1:0]    occ_r, occ_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [SIZE_W-1:0]    cnt_r, cnt_nxt;
  res_t                 res_r, res_nxt;

  logic [IDX_W-1:0]     adv_in;
  logic [IDX_W-1:0]     adv_out;
  logic [SIZE_W-1:0]    adv_sum;
  logic [SIZE_W-1:0]    cfg_size;
  logic                 full;
  logic                 empty;

  assign full  = (occ_r >= size_r);
  assign empty = (occ_r == '0);

  // Shared index unit: one increment with wrap at the configured size.
  always_comb begin
    adv_sum = SIZE_W'(adv_in) + SIZE_W'(1);
    adv_out = (adv_sum >= size_r) ? '0 : IDX_W'(adv_sum);
  end

  // A size of zero behaves as one; anything beyond the storage saturates.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_size = SIZE_W'(1);
    end else if (32'(cfg_wr_data) > DEPTH) begin
      cfg_size = SIZE_W'(DEPTH);
    end else begin
      cfg_size = SIZE_W'(cfg_wr_data);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (out_free) begin
          if (op_r == OP_DISPLAY && !res_r.last) begin
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    res_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = val_r;
    ram_re    = 1'b0;
    ram_raddr = head_r;
    adv_in    = tail_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EXEC: begin
        case (op_r)
          OP_INSERT: begin
            adv_in = tail_r;
            ram_we = !full;
          end
          OP_DELETE: begin
            adv_in = head_r;
            ram_re = !empty;
          end
          OP_DISPLAY: begin
            adv_in    = walk_r;
            ram_re    = !empty;
            ram_raddr = walk_r;
          end
          default: begin
            adv_in = tail_r;
          end
        endcase
      end
      S_PUT: begin
        res_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Pointer and occupancy updates.
  always_comb begin
    op_nxt   = op_r;
    val_nxt  = val_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    walk_nxt = walk_r;
    occ_nxt  = occ_r;
    size_nxt = size_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;

    if (state_r == S_IDLE && in_valid) begin
      op_nxt   = op_t'(in_operation);
      val_nxt  = in_value;
      walk_nxt = head_r;
      cnt_nxt  = '0;
    end

    if (state_r == S_EXEC) begin
      case (op_r)
        OP_INSERT: begin
          if (full) begin
            res_nxt = '{status: ST_FULL, last: 1'b1, from_ram: 1'b0};
          end else begin
            tail_nxt = adv_out;
            occ_nxt  = occ_r + SIZE_W'(1);
            res_nxt  = '{status: ST_OK, last: 1'b1, from_ram: 1'b0};
          end
        end
        OP_DELETE: begin
          if (empty) begin
            res_nxt = '{status: ST_EMPTY, last: 1'b1, from_ram: 1'b0};
          end else begin
            occ_nxt = occ_r - SIZE_W'(1);
            res_nxt = '{status: ST_OK, last: 1'b1, from_ram: 1'b1};
            // Draining the queue brings both pointers back to the start.
            if (occ_r == SIZE_W'(1)) begin
              head_nxt = '0;
              tail_nxt = '0;
            end else begin
              head_nxt = adv_out;
            end
          end
        end
        OP_DISPLAY: begin
          if (empty) begin
            res_nxt = '{status: ST_EMPTY, last: 1'b1, from_ram: 1'b0};
          end else begin
            walk_nxt = adv_out;
            cnt_nxt  = cnt_r + SIZE_W'(1);
            res_nxt  = '{status: ST_OK, last: (cnt_r + SIZE_W'(1) == occ_r), from_ram: 1'b1};
          end
        end
        default: begin
          res_nxt = '{status: ST_BAD_OP, last: 1'b1, from_ram: 1'b0};
        end
      endcase
    end

    // A size write flushes the queue.
    if (cfg_wr_en) begin
      size_nxt = cfg_size;
      head_nxt = '0;
      tail_nxt = '0;
      occ_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      size_r  <= (SIZE_RESET > DEPTH) ? SIZE_W'(DEPTH) : SIZE_W'(SIZE_RESET);
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      size_r  <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    walk_r <= walk_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= size_r)
    else $error("occupancy exceeds the configured size");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (SIZE_W'(head_r) < size_r) && (SIZE_W'(tail_r) < size_r))
    else $error("head or tail beyond the wrap point");

  a_empty_home: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("empty queue with pointers away from the start");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("storage written and read in the same cycle");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted item did not start execution");

endmodule

@@ hdl/circular_queue.sv @@
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_operation, in_value
// out      out_valid / out_ready  out_status, out_element, out_last
// cfg      cfg_wr_en              cfg_wr_data (queue size, flushes the queue)
//
// An item is taken in the idle state, executed in the next cycle and its result
// loaded into the output register from the output step once that register is free.
// A display walk does one storage read and then one output load for each stored entry.
// Reset is synchronous; no clearing pass is needed, as entries are read only once written.
// A stalled output holds the sequencer in its output step; no new item is taken meanwhile.
module circular_queue
  import cq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_element,
  output logic                     out_last,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                 out_free;
  logic                 res_load;
  res_t                 res;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [DATA_W-1:0]    out_element_r;
  logic                 out_last_r;

  cq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_value     (in_value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr)
  );

  cq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The output register frees up in the same cycle as its beat is taken.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r  <= res.status;
      out_last_r    <= res.last;
      out_element_r <= res.from_ram ? ram_rdata : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
  import cq_pkg::*;
();

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  element;
    logic               last;
  } beat_t;

  // One line of the directed table: either a size write (value holds the size)
  // or an operation, with its single result typed in where it is obvious.
  typedef struct packed {
    bit                 is_cfg;
    op_t                op;
    logic [DATA_W-1:0]  value;
    bit                 typed;
    status_t            status;
    logic [DATA_W-1:0]  element;
  } dir_row_t;

  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES    = 9;
  localparam logic [CFG_W-1:0] PHASE_SIZE [NUM_PHASES] = '{6'd32, 6'd1, 6'd7, 6'd63, 6'd0,
                                                            6'd2, 6'd45, 6'd16, 6'd32};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{70, 30, 45, 70, 25, 35, 70, 45, 60};

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          in_operation;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_element;
  logic                     out_last;
  logic                     cfg_wr_en;
  logic [CFG_W-1:0]         cfg_wr_data;

  circular_queue u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_element  (out_element),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Shadow copy of the ring and its pointers.
  logic [DATA_W-1:0] ring_mem [DEPTH_DEF];
  int unsigned       ring_head;
  int unsigned       ring_tail;
  int unsigned       ring_count;
  logic [CFG_W-1:0]  ring_size;

  beat_t replies[$];
  beat_t step_beats[$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned beats_seen;
  int unsigned size_writes;
  int unsigned full_hits;
  int unsigned wide_displays;

  dir_row_t dir_rows[$];

  function automatic int unsigned ring_span();
    if (ring_size == 0) return 1;
    if (ring_size > DEPTH_DEF) return DEPTH_DEF;
    return ring_size;
  endfunction

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= ring_span()) ? 0 : idx + 1;
  endfunction

  function automatic void push_beat(status_t st, logic [DATA_W-1:0] el, logic lst);
    beat_t b;
    b.status  = st;
    b.element = el;
    b.last    = lst;
    step_beats.push_back(b);
  endfunction

  // Works out the beats one operation produces and updates the shadow ring.
  function automatic void ring_apply(op_t op, logic [DATA_W-1:0] val);
    int unsigned idx;
    step_beats.delete();
    case (op)
      OP_INSERT: begin
        if (ring_count >= ring_span()) begin
          push_beat(ST_FULL, '0, 1'b1);
          full_hits++;
        end else begin
          ring_mem[ring_tail] = val;
          ring_tail = ring_next(ring_tail);
          ring_count++;
          push_beat(ST_OK, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (ring_count == 0) begin
          push_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          push_beat(ST_OK, ring_mem[ring_head], 1'b1);
          ring_count--;
          if (ring_count == 0) begin
            ring_head = 0;
            ring_tail = 0;
          end else begin
            ring_head = ring_next(ring_head);
          end
        end
      end
      OP_DISPLAY: begin
        if (ring_count == 0) begin
          push_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          if (ring_count == ring_span() && ring_count > 8) wide_displays++;
          idx = ring_head;
          for (int unsigned i = 0; i < ring_count; i++) begin
            push_beat(ST_OK, ring_mem[idx], i + 1 == ring_count);
            idx = ring_next(idx);
          end
        end
      end
      default: begin
        push_beat(ST_BAD_OP, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Presents one beat on the input channel and records what it should produce.
  task automatic send_item(op_t op, logic [DATA_W-1:0] val, bit typed, status_t st,
                           logic [DATA_W-1:0] el);
    beat_t b;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    do @(posedge clk); while (!in_ready);
    ring_apply(op, val);
    if (typed) begin
      b.status  = st;
      b.element = el;
      b.last    = 1'b1;
      replies.push_back(b);
    end else begin
      foreach (step_beats[i]) replies.push_back(step_beats[i]);
    end
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A size write flushes the queue, so the shadow pointers return to zero too.
  task automatic set_size(logic [CFG_W-1:0] sz);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sz;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    ring_size  = sz;
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
    size_writes++;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (replies.size() == 0) begin
        report_mismatch("unexpected beat (status)", DATA_W'(out_status), '0);
      end else begin
        want = replies.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
        if (out_element !== want.element)
          report_mismatch("element", out_element, want.element);
        if (out_last !== want.last)
          report_mismatch("last", DATA_W'(out_last), DATA_W'(want.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Run did not finish in time, %0d beats still owed.", replies.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    op_t               op;
    logic [DATA_W-1:0] val;
    int unsigned       pick;
    bit                filling;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_INSERT;
    in_value     = '0;
    out_ready    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    tx_idle_pct  = 29;
    rx_idle_pct  = 81;
    mismatches   = 0;
    items_sent   = 0;
    beats_seen   = 0;
    size_writes  = 0;
    full_hits    = 0;
    wide_displays = 0;
    ring_head    = 0;
    ring_tail    = 0;
    ring_count   = 0;
    ring_size    = SIZE_RESET;

    dir_rows = '{
      '{1'b0, OP_DELETE,  32'h0000_0000, 1'b1, ST_EMPTY,  32'h0000_0000},
      '{1'b0, OP_DISPLAY, 32'h0000_0000, 1'b1, ST_EMPTY,  32'h0000_0000},
      '{1'b0, OP_INVALID, 32'hFFFF_FFFF, 1'b1, ST_BAD_OP, 32'h0000_0000},
      '{1'b0, OP_INSERT,  32'h7FFF_FFFF, 1'b1, ST_OK,     32'h0000_0000},
      '{1'b0, OP_INSERT,  32'h8000_0000, 1'b1, ST_OK,     32'h0000_0000},
      '{1'b0, OP_INSERT,  32'hFFFF_FFFF, 1'b1, ST_OK,     32'h0000_0000},
      '{1'b0, OP_DISPLAY, 32'h0000_0000, 1'b0, ST_OK,     32'h0000_0000},
      '{1'b0, OP_DELETE,  32'h1234_5678, 1'b1, ST_OK,     32'h7FFF_FFFF},
      '{1'b0, OP_INVALID, 32'h0000_0000, 1'b1, ST_BAD_OP, 32'h0000_0000},
      // Two entries are still held here; the size write must throw them away.
      '{1'b1, OP_INSERT,  32'd2,         1'b0, ST_OK,     32'h0000_0000},
      '{1'b0, OP_DISPLAY, 32'h0000_0000, 1'b1, ST_EMPTY,  32'h0000_0000},
      '{1'b0, OP_INSERT,  32'h0000_0001, 1'b1, ST_OK,     32'h0000_0000},
      '{1'b0, OP_INSERT,  32'h0000_0002, 1'b1, ST_OK,     32'h0000_0000},
      '{1'b0, OP_INSERT,  32'h0000_0003, 1'b1, ST_FULL,   32'h0000_0000},
      '{1'b0, OP_DELETE,  32'h0000_0000, 1'b1, ST_OK,     32'h0000_0001},
      '{1'b0, OP_INSERT,  32'h0000_0004, 1'b0, ST_OK,     32'h0000_0000},
      '{1'b0, OP_DISPLAY, 32'h0000_0000, 1'b0, ST_OK,     32'h0000_0000},
      '{1'b0, OP_DELETE,  32'h0000_0000, 1'b0, ST_OK,     32'h0000_0000},
      '{1'b0, OP_DELETE,  32'h0000_0000, 1'b0, ST_OK,     32'h0000_0000},
      '{1'b0, OP_DELETE,  32'h0000_0000, 1'b1, ST_EMPTY,  32'h0000_0000},
      // A size of zero behaves as a single entry.
      '{1'b1, OP_INSERT,  32'd0,         1'b0, ST_OK,     32'h0000_0000},
      '{1'b0, OP_INSERT,  32'h0000_0005, 1'b1, ST_OK,     32'h0000_0000},
      '{1'b0, OP_INSERT,  32'h0000_0006, 1'b1, ST_FULL,   32'h0000_0000},
      '{1'b0, OP_DISPLAY, 32'h0000_0000, 1'b0, ST_OK,     32'h0000_0000},
      '{1'b0, OP_DELETE,  32'h0000_0000, 1'b1, ST_OK,     32'h0000_0005},
      '{1'b1, OP_INSERT,  32'd63,        1'b0, ST_OK,     32'h0000_0000},
      '{1'b0, OP_INSERT,  32'h0000_0009, 1'b0, ST_OK,     32'h0000_0000},
      '{1'b0, OP_DELETE,  32'h0000_0000, 1'b0, ST_OK,     32'h0000_0000}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        set_size(dir_rows[i].value[CFG_W-1:0]);
      else
        send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed,
                  dir_rows[i].status, dir_rows[i].element);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 3) begin
        tx_idle_pct = 81;
        rx_idle_pct = 29;
      end else if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_size(PHASE_SIZE[p]);
      filling = 1'b1;
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        // Fill to the brim, linger at full for a while, then drain to empty.
        if (ring_count == ring_span() && $urandom_range(0, 2) == 0)
          filling = 1'b0;
        else if (ring_count == 0)
          filling = 1'b1;
        pick = $urandom_range(0, 99);
        if (filling)
          op = (pick < 78) ? OP_INSERT : (pick < 88) ? OP_DELETE :
               (pick < 96) ? OP_DISPLAY : OP_INVALID;
        else
          op = (pick < 12) ? OP_INSERT : (pick < 80) ? OP_DELETE :
               (pick < 95) ? OP_DISPLAY : OP_INVALID;
        case ($urandom_range(0, 9))
          0:       val = 32'h7FFF_FFFF;
          1:       val = 32'h8000_0000;
          default: val = $urandom;
        endcase
        send_item(op, val, 1'b0, ST_OK, '0);
      end
    end

    wait_idle();

    $display("Sent %0d items over %0d size settings (0 to 63), checked %0d result beats.",
             items_sent, size_writes, beats_seen);
    $display("Full refusals: %0d, displays of a full deep queue: %0d, mismatches: %0d.",
             full_hits, wide_displays, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/cq_pkg.sv
hdl/cq_ram.sv
hdl/cq_ctrl.sv
hdl/circular_queue.sv
bench/tb_top.sv
